### design/fbeq_pkg.sv
// Shared types and constants for the four-band equalizer.
// No dependencies; imported by every module of the block.
package fbeq_pkg;

  // Sample and filter widths
  localparam int unsigned SAMPLE_W   = 16;  // Q1.15 audio
  localparam int unsigned COEF_W     = 16;  // Q0.16 poles, Q4.12 gains
  localparam int unsigned STATE_W    = 24;  // Q2.22 filter state
  localparam int unsigned X_SHIFT    = 7;   // Q1.15 -> Q2.22
  localparam int unsigned OPA_W      = STATE_W + 1;       // differences and presence band
  localparam int unsigned OPB_W      = COEF_W + 1;        // unsigned coefficient, signed form
  localparam int unsigned PROD_W     = OPA_W + OPB_W;
  localparam int unsigned ACC_W      = PROD_W + 2;        // four products
  localparam int unsigned POLE_FRAC  = 16;
  localparam int unsigned SUM_SHIFT  = 19;

  localparam int unsigned CHANNELS_DEF = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BYPASS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_MID      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_BASS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_TREBLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_BASS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LOW_MID  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_HIGH_MID = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PRESENCE = 3'd7;

  localparam logic [COEF_W-1:0] POLE_RESET = 16'd0;
  localparam logic [COEF_W-1:0] GAIN_UNITY = 16'd4096;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       channel;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } out_word_t;

  typedef struct packed {
    logic [COEF_W-1:0] pole_mid;
    logic [COEF_W-1:0] pole_bass;
    logic [COEF_W-1:0] pole_treble;
    logic [COEF_W-1:0] gain_bass;
    logic [COEF_W-1:0] gain_low_mid;
    logic [COEF_W-1:0] gain_high_mid;
    logic [COEF_W-1:0] gain_presence;
  } cfg_t;

  // Operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_MID,
    MUL_BASS,
    MUL_TREB,
    MUL_G_BASS,
    MUL_G_LM,
    MUL_G_HM,
    MUL_G_PR
  } mul_sel_e;

  // Which filter takes its new output from the product register
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_MID,
    UPD_BASS,
    UPD_TREB
  } upd_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    upd_sel_e upd_sel;
    acc_op_e  acc_op;
    logic     out_load;
    logic     out_bypass;
  } cmd_t;

endpackage

### design/fbeq_ctrl.sv
// Sequencer of the four-band equalizer: handshakes and datapath commands.
// Depends on fbeq_pkg.
module fbeq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  logic          bypass_i,
  output fbeq_pkg::cmd_t cmd_o
);
  import fbeq_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MID_MUL  = 4'd1;
  localparam logic [3:0] ST_MID_UPD  = 4'd2;
  localparam logic [3:0] ST_BASS_MUL = 4'd3;
  localparam logic [3:0] ST_BASS_UPD = 4'd4;
  localparam logic [3:0] ST_TREB_MUL = 4'd5;
  localparam logic [3:0] ST_TREB_UPD = 4'd6;
  localparam logic [3:0] ST_G_LM     = 4'd7;
  localparam logic [3:0] ST_G_HM     = 4'd8;
  localparam logic [3:0] ST_G_PR     = 4'd9;
  localparam logic [3:0] ST_ACC_LAST = 4'd10;
  localparam logic [3:0] ST_DONE     = 4'd11;

  logic [3:0] state_q, state_d;
  logic       byp_q, byp_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d          = state_q;
    byp_d            = byp_q;
    cmd_o            = '0;
    cmd_o.mul_sel    = MUL_NONE;
    cmd_o.upd_sel    = UPD_NONE;
    cmd_o.acc_op     = ACC_HOLD;
    cmd_o.out_bypass = byp_q;
    in_ready_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          byp_d      = bypass_i;
          state_d    = bypass_i ? ST_DONE : ST_MID_MUL;
        end
      end
      ST_MID_MUL: begin
        cmd_o.mul_sel = MUL_MID;
        state_d       = ST_MID_UPD;
      end
      ST_MID_UPD: begin
        cmd_o.upd_sel = UPD_MID;
        state_d       = ST_BASS_MUL;
      end
      ST_BASS_MUL: begin
        cmd_o.mul_sel = MUL_BASS;
        state_d       = ST_BASS_UPD;
      end
      ST_BASS_UPD: begin
        cmd_o.upd_sel = UPD_BASS;
        state_d       = ST_TREB_MUL;
      end
      ST_TREB_MUL: begin
        cmd_o.mul_sel = MUL_TREB;
        state_d       = ST_TREB_UPD;
      end
      ST_TREB_UPD: begin
        cmd_o.upd_sel = UPD_TREB;
        cmd_o.mul_sel = MUL_G_BASS;
        state_d       = ST_G_LM;
      end
      ST_G_LM: begin
        cmd_o.mul_sel = MUL_G_LM;
        cmd_o.acc_op  = ACC_LOAD;
        state_d       = ST_G_HM;
      end
      ST_G_HM: begin
        cmd_o.mul_sel = MUL_G_HM;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_G_PR;
      end
      ST_G_PR: begin
        cmd_o.mul_sel = MUL_G_PR;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_ACC_LAST;
      end
      ST_ACC_LAST: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      byp_q       <= byp_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### design/fbeq_dpath.sv
// Datapath of the four-band equalizer: filter state, shared multiplier,
// accumulator and output register. Depends on fbeq_pkg.
module fbeq_dpath #(
  parameter int unsigned CHANNELS = fbeq_pkg::CHANNELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbeq_pkg::cmd_t      cmd_i,
  input  fbeq_pkg::cfg_t      cfg_i,
  input  fbeq_pkg::in_word_t  in_word_i,
  output fbeq_pkg::out_word_t out_word_o
);
  import fbeq_pkg::*;

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic [CH_W-1:0]            ch_q;
  logic signed [STATE_W-1:0]  x;

  logic signed [STATE_W-1:0]  mid_st_q  [CHANNELS];
  logic signed [STATE_W-1:0]  bass_st_q [CHANNELS];
  logic signed [STATE_W-1:0]  treb_st_q [CHANNELS];

  logic signed [STATE_W-1:0]  low_q, bass_q, treb_q, hi_q, lowmid_q;
  logic signed [OPA_W-1:0]    pres_q;

  logic signed [OPA_W-1:0]    opa;
  logic signed [OPB_W-1:0]    opb;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;

  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [STATE_W-1:0]  filt_src, filt_new;

  logic signed [ACC_W-1:0]    sum_rnd;
  logic signed [SAMPLE_W-1:0] sat_val;
  logic                       sat_clip;

  out_word_t                  out_q;

  // Q1.15 -> Q2.22, sign carried into the top bit
  assign x = {sample_q[SAMPLE_W-1], sample_q, {X_SHIFT{1'b0}}};

  // Multiplier operands
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd_i.mul_sel)
      MUL_NONE: begin
        opa = '0;
        opb = '0;
      end
      MUL_MID: begin
        opa = OPA_W'(mid_st_q[ch_q]) - OPA_W'(x);
        opb = {1'b0, cfg_i.pole_mid};
      end
      MUL_BASS: begin
        opa = OPA_W'(bass_st_q[ch_q]) - OPA_W'(low_q);
        opb = {1'b0, cfg_i.pole_bass};
      end
      MUL_TREB: begin
        opa = OPA_W'(treb_st_q[ch_q]) - OPA_W'(hi_q);
        opb = {1'b0, cfg_i.pole_treble};
      end
      MUL_G_BASS: begin
        opa = OPA_W'(bass_q);
        opb = {1'b0, cfg_i.gain_bass};
      end
      MUL_G_LM: begin
        opa = OPA_W'(lowmid_q);
        opb = {1'b0, cfg_i.gain_low_mid};
      end
      MUL_G_HM: begin
        opa = OPA_W'(treb_q);
        opb = {1'b0, cfg_i.gain_high_mid};
      end
      MUL_G_PR: begin
        opa = pres_q;
        opb = {1'b0, cfg_i.gain_presence};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Filter update: src + round(prod / 2^16), ties toward +inf
  assign prod_rnd = (prod_q + PROD_W'(1 << (POLE_FRAC - 1))) >>> POLE_FRAC;

  always_comb begin
    unique case (cmd_i.upd_sel)
      UPD_MID:  filt_src = x;
      UPD_BASS: filt_src = low_q;
      UPD_TREB: filt_src = hi_q;
      default:  filt_src = x;
    endcase
    filt_new = filt_src + prod_rnd[STATE_W-1:0];
  end

  // Band sum rounding and saturation
  always_comb begin
    sum_rnd  = (acc_q + ACC_W'(1 << (SUM_SHIFT - 1))) >>> SUM_SHIFT;
    sat_clip = 1'b0;
    sat_val  = sum_rnd[SAMPLE_W-1:0];
    if (sum_rnd > ACC_W'(32767)) begin
      sat_val  = 16'sh7fff;
      sat_clip = 1'b1;
    end else if (sum_rnd < -ACC_W'(32768)) begin
      sat_val  = 16'sh8000;
      sat_clip = 1'b1;
    end
  end

  // Per-channel filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        mid_st_q[i]  <= '0;
        bass_st_q[i] <= '0;
        treb_st_q[i] <= '0;
      end
    end else begin
      unique case (cmd_i.upd_sel)
        UPD_MID:  mid_st_q[ch_q]  <= filt_new;
        UPD_BASS: bass_st_q[ch_q] <= filt_new;
        UPD_TREB: treb_st_q[ch_q] <= filt_new;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= in_word_i.sample_in;
      ch_q     <= (CHANNELS > 1) ? CH_W'(in_word_i.channel) : '0;
    end
    unique case (cmd_i.upd_sel)
      UPD_MID:  low_q  <= filt_new;
      UPD_BASS: bass_q <= filt_new;
      UPD_TREB: treb_q <= filt_new;
      default: ;
    endcase
    // derived bands settle in the cycle after their sources
    hi_q     <= x - low_q;
    lowmid_q <= low_q - bass_q;
    pres_q   <= OPA_W'(hi_q) - OPA_W'(treb_q);
    prod_q   <= opa * opb;
    unique case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= ACC_W'(prod_q);
      ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
      default: ;
    endcase
    if (cmd_i.out_load) begin
      if (cmd_i.out_bypass) begin
        out_q.sample_out <= sample_q;
        out_q.clipped    <= 1'b0;
      end else begin
        out_q.sample_out <= sat_val;
        out_q.clipped    <= sat_clip;
      end
    end
  end

  assign out_word_o = out_q;

endmodule

### design/four_band_equalizer.sv
// Four-band one-pole crossover equalizer, top level.
// Depends on fbeq_pkg, fbeq_ctrl and fbeq_dpath.
//
// Takes one Q1.15 sample word with a channel number and returns one
// equalized Q1.15 word with a clip flag. Three one-pole lowpass filters
// (mid, then bass on the low part, then treble on the high remainder) split
// the sample into bass, low-mid, high-mid and presence bands; each band is
// scaled by its Q4.12 gain, the four are summed, rounded and saturated.
// Filter state is kept per channel (channel modulo CHANNELS) and cleared by
// reset. The next word is taken only once the previous one is in the
// output register, so one word is worked on at a time; in bypass a word
// skips the filters and passes unchanged with the clip flag clear. The
// pace is set by the single shared 25x17 multiplier, serving the three
// dependent filter steps and four band gains in turn, products registered.
// The output register holds a finished word while the next one is taken
// in and worked on; a word waits only if the previous result is still
// unread when it completes. Configuration is a plain write port: poles are
// Q0.16, gains Q4.12 (4096 = unity, the reset value), poles reset to 0.
// Write configuration only while the block is idle.
module four_band_equalizer #(
  parameter int unsigned CHANNELS = fbeq_pkg::CHANNELS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  fbeq_pkg::in_word_t                    in_word_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output fbeq_pkg::out_word_t                   out_word_o,
  input  logic                                  cfg_we_i,
  input  logic [fbeq_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [fbeq_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import fbeq_pkg::*;

  // Configuration registers
  logic bypass_q;
  cfg_t cfg_q;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q            <= 1'b0;
      cfg_q.pole_mid      <= POLE_RESET;
      cfg_q.pole_bass     <= POLE_RESET;
      cfg_q.pole_treble   <= POLE_RESET;
      cfg_q.gain_bass     <= GAIN_UNITY;
      cfg_q.gain_low_mid  <= GAIN_UNITY;
      cfg_q.gain_high_mid <= GAIN_UNITY;
      cfg_q.gain_presence <= GAIN_UNITY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BYPASS:        bypass_q            <= cfg_data_i[0];
        REG_POLE_MID:      cfg_q.pole_mid      <= cfg_data_i;
        REG_POLE_BASS:     cfg_q.pole_bass     <= cfg_data_i;
        REG_POLE_TREBLE:   cfg_q.pole_treble   <= cfg_data_i;
        REG_GAIN_BASS:     cfg_q.gain_bass     <= cfg_data_i;
        REG_GAIN_LOW_MID:  cfg_q.gain_low_mid  <= cfg_data_i;
        REG_GAIN_HIGH_MID: cfg_q.gain_high_mid <= cfg_data_i;
        REG_GAIN_PRESENCE: cfg_q.gain_presence <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: owns both handshakes and steps the datapath
  fbeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bypass_i    (bypass_q),
    .cmd_o       (cmd)
  );

  // Filters, shared multiplier, band accumulator, output register
  fbeq_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg_q),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule
